FILE: design/lzwd_pkg.sv
// lzwd_pkg: types and constants shared by the LZ window byte decompressor.
// No dependencies.
`timescale 1ns / 1ps

package lzwd_pkg;

  localparam int HIST_AW = 12;
  localparam int LANE_W  = 3;

  localparam logic [8:0] LONG_BIAS = 9'h12;
  localparam logic [3:0] NIB_MASK  = 4'hF;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BEFORE = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    logic [1:0]  status;
  } out_t;

  // One copy command from the parser to the byte engine.
  typedef struct packed {
    logic        lit;
    logic [7:0]  lit_val;
    logic [8:0]  len;
    logic [12:0] back_dist;
    logic [8:0]  zeros;
    logic        trunc;
    logic        done;
  } cmd_t;

endpackage

FILE: design/lz_window_byte_decompressor.sv
// Each command moves from the command queue to the engine's command register, then to
// the history read stage and lane packer; full or final packets are registered out.
// Parser input is taken while the queue is not full. A back reference of length L is
// expanded one byte per cycle via the single history read port unless output stalls.
// A two-entry command queue lets the parser run ahead of the byte engine.
// Reset: synchronous; clears control state. History is not cleared.
`timescale 1ns / 1ps

module lz_window_byte_decompressor import lzwd_pkg::*; #(
  parameter int OUT_LANES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic push, full, pop, cmd_valid;
  cmd_t wr_cmd, rd_cmd;

  lzwd_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .push(push), .cmd(wr_cmd), .full(full)
  );

  lzwd_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wr_cmd(wr_cmd), .full(full),
    .pop(pop), .valid(cmd_valid), .rd_cmd(rd_cmd)
  );

  lzwd_back #(.OUT_LANES(OUT_LANES)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_in(rd_cmd), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.byte_count != 4'd0 && out_data.byte_count <= 4'(OUT_LANES)))
    else $error("packet byte count out of range");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stream_done) |-> out_data.run_last)
    else $error("stream done on a packet that is not the last of its run");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command pushed into full queue");
`endif

endmodule

FILE: design/lzwd_front.sv
// lzwd_front: header, flag and token parser; emits copy commands.
// Depends on lzwd_pkg.
`timescale 1ns / 1ps

module lzwd_front import lzwd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic push,
  output cmd_t cmd,
  input  logic full
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_FLAG, PH_TOK1, PH_TOK2, PH_TOK3, PH_DONE
  } phase_t;

  phase_t      phase, ph_eff, phase_next;
  logic [3:0]  hc;
  logic [31:0] size, size_hdr;
  logic [31:0] produced;
  logic [7:0]  flag_bits;
  logic [3:0]  flags_left, flags_dec;
  logic [7:0]  tok1, tok2;

  logic        accept, emit;
  logic [7:0]  b;
  logic [8:0]  len_raw, len_eff;
  logic [12:0] back_dist, zspan;
  logic [31:0] remain, prod_new;
  logic        trunc;
  logic [8:0]  zeros;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign b        = in_data.in_byte;
  assign ph_eff   = in_data.stream_start ? PH_HEADER : phase;
  assign flags_dec = flags_left - 4'd1;

  always_comb begin
    emit    = 1'b0;
    len_raw = 9'd1;
    unique case (ph_eff)
      PH_TOK1: begin
        emit = flag_bits[7];
      end
      PH_TOK2: begin
        emit    = tok1[7:4] != 4'd0;
        len_raw = {5'd0, tok1[7:4]} + 9'd2;
      end
      PH_TOK3: begin
        emit    = 1'b1;
        len_raw = {1'b0, b} + LONG_BIAS;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    back_dist = {1'b0, tok1[3:0] & NIB_MASK, (ph_eff == PH_TOK3) ? tok2 : b} + 13'd1;
    remain   = size - produced;
    trunc    = {23'd0, len_raw} > remain;
    len_eff  = trunc ? remain[8:0] : len_raw;
    prod_new = produced + {23'd0, len_eff};
    zspan    = back_dist - produced[12:0];
    if ((ph_eff == PH_TOK1) || (produced >= {19'd0, back_dist})) begin
      zeros = 9'd0;
    end else if ({4'd0, len_eff} < zspan) begin
      zeros = len_eff;
    end else begin
      zeros = zspan[8:0];
    end
    size_hdr = ((hc >= 4'd4) && (hc <= 4'd7)) ? {size[23:0], b} : size;
    if (in_data.stream_start) size_hdr = 32'd0;
    phase_next = (flags_dec == 4'd0) ? PH_FLAG : PH_TOK1;
    if (prod_new == size) phase_next = PH_DONE;
  end

  assign push          = accept && emit;
  assign cmd.lit       = ph_eff == PH_TOK1;
  assign cmd.lit_val   = b;
  assign cmd.len       = len_eff;
  assign cmd.back_dist = back_dist;
  assign cmd.zeros     = zeros;
  assign cmd.trunc     = trunc;
  assign cmd.done      = prod_new == size;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hc         <= 4'd0;
      size       <= 32'd0;
      produced   <= 32'd0;
      flag_bits  <= 8'd0;
      flags_left <= 4'd0;
      tok1       <= 8'd0;
      tok2       <= 8'd0;
    end else if (accept) begin
      if (in_data.stream_start) begin
        produced   <= 32'd0;
        flag_bits  <= 8'd0;
        flags_left <= 4'd0;
        tok1       <= 8'd0;
        tok2       <= 8'd0;
      end
      unique case (ph_eff)
        PH_HEADER: begin
          if (in_data.stream_start) begin
            size <= 32'd0;
            hc   <= 4'd1;
          end else begin
            size <= size_hdr;
            if (hc == 4'd15) begin
              hc    <= 4'd0;
              phase <= (size_hdr == 32'd0) ? PH_DONE : PH_FLAG;
            end else begin
              hc <= hc + 4'd1;
            end
          end
          if (in_data.stream_start) phase <= PH_HEADER;
        end
        PH_FLAG: begin
          flag_bits  <= b;
          flags_left <= 4'd8;
          phase      <= PH_TOK1;
        end
        PH_TOK1: begin
          if (flag_bits[7]) begin
            flag_bits  <= {flag_bits[6:0], 1'b0};
            flags_left <= flags_dec;
            produced   <= prod_new;
            phase      <= phase_next;
          end else begin
            tok1  <= b;
            phase <= PH_TOK2;
          end
        end
        PH_TOK2: begin
          tok2 <= b;
          if (emit) begin
            flag_bits  <= {flag_bits[6:0], 1'b0};
            flags_left <= flags_dec;
            produced   <= prod_new;
            phase      <= phase_next;
          end else begin
            phase <= PH_TOK3;
          end
        end
        PH_TOK3: begin
          flag_bits  <= {flag_bits[6:0], 1'b0};
          flags_left <= flags_dec;
          produced   <= prod_new;
          phase      <= phase_next;
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

endmodule

FILE: design/lzwd_cmd_fifo.sv
// lzwd_cmd_fifo: two-entry command queue between parser and byte engine.
// Depends on lzwd_pkg.
`timescale 1ns / 1ps

module lzwd_cmd_fifo import lzwd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t rd_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full   = count == 2'd2;
  assign valid  = count != 2'd0;
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/lzwd_back.sv
// lzwd_back: byte engine; history window, lane packing, output register.
// Depends on lzwd_pkg.
`timescale 1ns / 1ps

module lzwd_back import lzwd_pkg::*; #(
  parameter int OUT_LANES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd_in,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [7:0]  hist [1 << HIST_AW];

  logic              active;
  cmd_t              cur;
  logic [8:0]        cnt, zcnt;
  logic [HIST_AW-1:0] pos;

  logic              s2_valid, s2_zero, s2_lit, s2_dist1, s2_last, s2_trunc, s2_done;
  logic [7:0]        s2_litval;
  logic [HIST_AW-1:0] s2_pos;
  logic [7:0]        rdata, last_byte, s2_byte;

  logic [63:0]       acc, acc_new;
  logic [LANE_W-1:0] lanes;
  logic [3:0]        lanes_inc;
  logic              bad, bad_new;
  logic              emit, s2_can, exec, advance, issue;

  always_comb begin
    if (s2_lit) s2_byte = s2_litval;
    else if (s2_zero) s2_byte = 8'd0;
    else if (s2_dist1) s2_byte = last_byte;
    else s2_byte = rdata;
    lanes_inc = {1'b0, lanes} + 4'd1;
    acc_new = acc;
    acc_new[lanes*8 +: 8] = s2_byte;
    bad_new = bad || s2_zero;
  end

  assign emit    = s2_valid && ((lanes_inc == 4'(OUT_LANES)) || s2_last);
  assign s2_can  = !emit || !out_valid || out_ready;
  assign exec    = s2_valid && s2_can;
  assign advance = !s2_valid || s2_can;
  assign issue   = active && advance;
  assign pop     = cmd_valid && (!active || (issue && (cnt == 9'd1)));

  always_ff @(posedge clk) begin
    if (exec) hist[s2_pos] <= s2_byte;
    if (issue) rdata <= hist[pos - cur.back_dist[HIST_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      s2_valid  <= 1'b0;
      acc       <= 64'd0;
      lanes     <= '0;
      bad       <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (exec && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (exec) begin
        last_byte <= s2_byte;
        if (emit) begin
          out_data.out_bytes   <= acc_new;
          out_data.byte_count  <= lanes_inc;
          out_data.run_last    <= s2_last;
          out_data.stream_done <= s2_last && s2_done;
          out_data.status      <= bad_new ? ST_BEFORE : (s2_trunc ? ST_TRUNC : ST_OK);
          acc                  <= 64'd0;
          lanes                <= '0;
          bad                  <= 1'b0;
        end else begin
          acc   <= acc_new;
          lanes <= lanes_inc[LANE_W-1:0];
          bad   <= bad_new;
        end
      end
      if (issue) begin
        s2_pos    <= pos;
        s2_zero   <= zcnt != 9'd0;
        s2_lit    <= cur.lit;
        s2_litval <= cur.lit_val;
        s2_dist1  <= cur.back_dist == 13'd1;
        s2_last   <= cnt == 9'd1;
        s2_trunc  <= cur.trunc;
        s2_done   <= cur.done;
        pos       <= pos + 1'b1;
      end
      s2_valid <= issue ? 1'b1 : (exec ? 1'b0 : s2_valid);
      if (pop) begin
        cur    <= cmd_in;
        cnt    <= cmd_in.len;
        zcnt   <= cmd_in.zeros;
        active <= 1'b1;
      end else if (issue) begin
        cnt <= cnt - 9'd1;
        if (zcnt != 9'd0) zcnt <= zcnt - 9'd1;
        if (cnt == 9'd1) active <= 1'b0;
      end
    end
  end

endmodule
